### rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the string interning table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int SLOTS_DEF       = 4096;
    localparam int STORE_BYTES_DEF = 65536;
    localparam int MAX_LEN_DEF     = 32;

    localparam int LEN_W       = 6;
    localparam int SYM_W       = 16;
    localparam int HASH_W      = 32;
    localparam int FILL_W      = 17;
    localparam int SLOTS_CFG_W = 13;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 1'd1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    localparam logic REQ_INTERN = 1'b0;
    localparam logic REQ_FETCH  = 1'b1;

    localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST = 13'd4096;
    localparam logic [CFG_W-1:0]       CAP_RST   = 17'd65536;

    // one command from the front part to the back part
    typedef struct packed {
        logic                kind;
        logic [SYM_W-1:0]    symbol;
        logic [HASH_W-1:0]   hash;
        logic [LEN_W-1:0]    len;
        logic                over;
    } t_cmd;

    // back part status seen by the front part
    typedef struct packed {
        logic clearing;
        logic intern_done;
    } t_bk_stat;

endpackage

### rtl/string_interning_table.sv
// ----------------------------------------------------------------------------
// string_interning_table
// Interns byte strings into 16-bit symbols and streams stored strings back.
// ----------------------------------------------------------------------------
// Input channel: one item per transfer. tuser 0 is an intern byte (tdata[7:0],
// zero ends the string), tuser 1 fetches the string at symbol tdata[23:8].
// Output channel: one result per transfer, tlast on the last result of a run.
// An intern string end gives one result; a fetch gives one result per byte,
// terminator included, at most MAX_LEN+1.
// Intern bytes that are not a terminator are taken one per cycle while
// s_axis_tready is high. A string end passes dispatch, bit-serial hash
// modulo, a probe walk and byte compare (a read and a check state per slot
// or byte), a capacity check, append and the result; an empty or too long
// string skips to the result. A fetch passes dispatch, then a read and an
// output state per returned byte. Both memories have a single port. While
// an intern end is being worked on, the input holds off until its result is out.
// After reset a clearing pass zeroes the slot table with s_axis_tready low;
// configuration writes are taken at any time.
// A stalled receiver holds the result register; the back part then waits.
// ----------------------------------------------------------------------------
module string_interning_table #(
    parameter int SLOTS       = sit_pkg::SLOTS_DEF,
    parameter int STORE_BYTES = sit_pkg::STORE_BYTES_DEF,
    parameter int MAX_LEN     = sit_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sit_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // char_byte, symbol
    input  logic                            s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // status, symbol_res, char_byte_res
    output logic                            m_axis_tlast   // last
);
    logic [sit_pkg::SLOTS_CFG_W-1:0] r_slots_cfg;
    logic [sit_pkg::CFG_W-1:0]       r_cap_cfg;

    logic                        push;
    sit_pkg::t_cmd               push_cmd;
    logic                        q_full;
    logic                        q_valid;
    sit_pkg::t_cmd               q_cmd;
    logic                        pop;
    sit_pkg::t_bk_stat           stat;
    logic [sit_pkg::LEN_W-1:0]   pend_idx;
    logic [7:0]                  pend_byte;
    logic [1:0]                  status;
    logic [sit_pkg::SYM_W-1:0]   symbol;
    logic [7:0]                  char_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_cfg <= sit_pkg::SLOTS_RST;
            r_cap_cfg   <= sit_pkg::CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sit_pkg::CFG_SLOTS: r_slots_cfg <= i_cfg_data[sit_pkg::SLOTS_CFG_W-1:0];
                sit_pkg::CFG_CAP:   r_cap_cfg   <= i_cfg_data;
                default:            r_cap_cfg   <= r_cap_cfg;
            endcase
        end
    end

    sit_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_q_full      (q_full),
        .i_stat        (stat),
        .i_pend_idx    (pend_idx),
        .o_pend_byte   (pend_byte)
    );

    sit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    sit_back #(
        .SLOTS       (SLOTS),
        .STORE_BYTES (STORE_BYTES),
        .MAX_LEN     (MAX_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slots_cfg   (r_slots_cfg),
        .i_cap_cfg     (r_cap_cfg),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_stat        (stat),
        .o_pend_idx    (pend_idx),
        .i_pend_byte   (pend_byte),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_status      (status),
        .o_symbol      (symbol),
        .o_char        (char_res),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, char_res, symbol, status};

endmodule

### rtl/sit_queue.sv
// ----------------------------------------------------------------------------
// sit_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sit_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sit_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sit_pkg::t_cmd   o_data
);
    sit_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Input side: hashes and buffers intern bytes, queues string ends and fetches.
// ----------------------------------------------------------------------------
module sit_front #(
    parameter int MAX_LEN = sit_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,
    input  logic                        s_axis_tuser,
    output logic                        o_push,
    output sit_pkg::t_cmd               o_cmd,
    input  logic                        i_q_full,
    input  sit_pkg::t_bk_stat           i_stat,
    input  logic [sit_pkg::LEN_W-1:0]   i_pend_idx,
    output logic [7:0]                  o_pend_byte
);
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [7:0]                  r_pend [MAX_LEN];
    logic [sit_pkg::LEN_W-1:0]   r_len;
    logic [sit_pkg::HASH_W-1:0]  r_hash;
    logic                        r_over;
    logic                        r_hold;

    logic                        xfer;
    logic [7:0]                  c;
    logic [sit_pkg::HASH_W-1:0]  n_hash;

    assign c             = s_axis_tdata[7:0];
    assign s_axis_tready = !r_hold && !i_q_full && !i_stat.clearing;
    assign xfer          = s_axis_tvalid && s_axis_tready;
    assign n_hash        = r_hash ^ ((r_hash << 5) + (r_hash >> 2) + {24'd0, c});
    assign o_pend_byte   = r_pend[i_pend_idx[PW-1:0]];

    // fetches and string ends go to the back part
    assign o_push = xfer && (s_axis_tuser == sit_pkg::REQ_FETCH || c == 8'd0);

    always_comb begin
        o_cmd        = '0;
        o_cmd.kind   = s_axis_tuser;
        o_cmd.symbol = s_axis_tdata[23:8];
        o_cmd.hash   = r_hash;
        o_cmd.len    = r_len;
        o_cmd.over   = r_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_hash <= '0;
            r_over <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (i_stat.intern_done) begin
                r_hold <= 1'b0;
            end
            if (xfer && s_axis_tuser == sit_pkg::REQ_INTERN) begin
                if (c == 8'd0) begin
                    // buffer stays put until the back part is done with it
                    r_hold <= 1'b1;
                    r_len  <= '0;
                    r_hash <= '0;
                    r_over <= 1'b0;
                end else begin
                    r_hash <= n_hash;
                    if (r_len < sit_pkg::LEN_W'(MAX_LEN)) begin
                        r_len <= r_len + sit_pkg::LEN_W'(1);
                    end else begin
                        r_over <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer && s_axis_tuser == sit_pkg::REQ_INTERN && c != 8'd0
                && r_len < sit_pkg::LEN_W'(MAX_LEN)) begin
            r_pend[r_len[PW-1:0]] <= c;
        end
    end

endmodule

### rtl/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back
// Back part: clearing pass, modulo, probe walk, string compare, append, fetch and results.
// ----------------------------------------------------------------------------
module sit_back #(
    parameter int SLOTS       = sit_pkg::SLOTS_DEF,
    parameter int STORE_BYTES = sit_pkg::STORE_BYTES_DEF,
    parameter int MAX_LEN     = sit_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sit_pkg::SLOTS_CFG_W-1:0]   i_slots_cfg,
    input  logic [sit_pkg::CFG_W-1:0]         i_cap_cfg,
    input  logic                              i_q_valid,
    input  sit_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output sit_pkg::t_bk_stat                 o_stat,
    output logic [sit_pkg::LEN_W-1:0]         o_pend_idx,
    input  logic [7:0]                        i_pend_byte,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [1:0]                        o_status,
    output logic [sit_pkg::SYM_W-1:0]         o_symbol,
    output logic [7:0]                        o_char,
    output logic                              o_last
);
    localparam int IW = $clog2(SLOTS);
    localparam int SW = $clog2(SLOTS + 1);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = sit_pkg::FILL_W;
    localparam int LW = sit_pkg::LEN_W;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DIV     = 4'd2;
    localparam logic [3:0] S_PRB_RD  = 4'd3;
    localparam logic [3:0] S_PRB_CHK = 4'd4;
    localparam logic [3:0] S_CMP_RD  = 4'd5;
    localparam logic [3:0] S_CMP_CHK = 4'd6;
    localparam logic [3:0] S_CHECK   = 4'd7;
    localparam logic [3:0] S_APP     = 4'd8;
    localparam logic [3:0] S_RES     = 4'd9;
    localparam logic [3:0] S_FET_RD  = 4'd10;
    localparam logic [3:0] S_FET_OUT = 4'd11;

    logic [15:0] slot_mem  [SLOTS];
    logic [7:0]  store_mem [STORE_BYTES];

    logic [3:0]                   r_state;
    sit_pkg::t_cmd                r_cmd;
    logic [SW-1:0]                r_rem;
    logic [sit_pkg::HASH_W-1:0]   r_div_hash;
    logic [4:0]                   r_div_cnt;
    logic [IW-1:0]                r_idx;
    logic [SW-1:0]                r_n;
    logic [15:0]                  r_off;
    logic [LW-1:0]                r_k;
    logic [FW-1:0]                r_addr;
    logic [SW-1:0]                r_count;
    logic [FW-1:0]                r_fill;
    logic [1:0]                   r_res_st;
    logic [15:0]                  r_res_sym;
    logic                         r_done;
    logic [15:0]                  r_slot_q;
    logic [7:0]                   r_store_q;
    logic                         r_oob;

    logic [FW-1:0]   sl_ext;
    logic [SW-1:0]   slots;
    logic [FW-1:0]   cap;
    logic            out_free;
    logic            out_load;
    logic [SW:0]     div_t;
    logic [SW:0]     div_r;
    logic [7:0]      rd_byte;
    logic [7:0]      exp_byte;
    logic [7:0]      fet_byte;
    logic [SW+1:0]   cnt1;
    logic [FW:0]     need;
    logic            full;
    logic            last_k;
    logic            slot_we;
    logic            store_we;
    logic [7:0]      store_wd;
    logic [IW-1:0]   idx_nx;

    // effective register values
    assign sl_ext = {{(FW-sit_pkg::SLOTS_CFG_W){1'b0}}, i_slots_cfg};
    assign slots  = (sl_ext < FW'(2))     ? SW'(2) :
                    (sl_ext > FW'(SLOTS)) ? SW'(SLOTS) : SW'(sl_ext);
    assign cap    = (i_cap_cfg > FW'(STORE_BYTES)) ? FW'(STORE_BYTES) : i_cap_cfg;

    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign out_load = out_free && ((r_state == S_RES) || (r_state == S_FET_OUT));
    assign last_k   = (r_k == r_cmd.len);

    // one restoring step of hash modulo slots
    assign div_t = {r_rem, r_div_hash[sit_pkg::HASH_W-1]};
    assign div_r = (div_t >= {1'b0, slots}) ? div_t - {1'b0, slots} : div_t;

    assign rd_byte  = r_oob ? 8'd0 : r_store_q;
    assign exp_byte = last_k ? 8'd0 : i_pend_byte;
    assign fet_byte = (r_k == LW'(MAX_LEN)) ? 8'd0 : rd_byte;

    assign cnt1 = (SW+2)'(r_count) + (SW+2)'(1);
    assign need = (FW+1)'(r_fill) + (FW+1)'(r_cmd.len) + (FW+1)'(1);
    assign full = (cnt1 >= (SW+2)'(slots)) || ((SW+2)'(slots) < (cnt1 << 1))
                  || (need > (FW+1)'(cap));

    assign idx_nx = (SW'(r_idx) + SW'(1) == slots) ? '0 : r_idx + IW'(1);

    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_pend_idx = r_k;
    assign o_stat.clearing    = (r_state == S_CLEAR);
    assign o_stat.intern_done = r_done;

    // clearing pass writes zero; an append writes the new offset
    assign slot_we  = (r_state == S_CLEAR) || ((r_state == S_APP) && last_k);
    assign store_we = (r_state == S_CLEAR) || (r_state == S_APP);
    assign store_wd = ((r_state == S_APP) && !last_k) ? i_pend_byte : 8'd0;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[r_idx] <= (r_state == S_CLEAR) ? 16'd0 : r_fill[15:0];
        end
        r_slot_q <= slot_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            store_mem[r_addr[AW-1:0]] <= store_wd;
        end
        r_store_q <= store_mem[r_addr[AW-1:0]];
        r_oob     <= (r_addr >= FW'(STORE_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_addr        <= '0;
            r_count       <= '0;
            r_fill        <= FW'(1);
            r_done        <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_done <= (r_state == S_RES) && out_free;
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_cmd;
                        r_k   <= '0;
                        if (i_cmd.kind == sit_pkg::REQ_FETCH) begin
                            r_addr  <= {1'b0, i_cmd.symbol};
                            r_state <= S_FET_RD;
                        end else if (i_cmd.over) begin
                            r_res_st  <= sit_pkg::ST_LONG;
                            r_res_sym <= '0;
                            r_state   <= S_RES;
                        end else if (i_cmd.len == '0) begin
                            r_res_st  <= sit_pkg::ST_OK;
                            r_res_sym <= '0;
                            r_state   <= S_RES;
                        end else begin
                            r_div_hash <= i_cmd.hash;
                            r_rem      <= '0;
                            r_div_cnt  <= '0;
                            r_state    <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem      <= div_r[SW-1:0];
                    r_div_hash <= r_div_hash << 1;
                    r_div_cnt  <= r_div_cnt + 5'd1;
                    if (r_div_cnt == 5'd31) begin
                        r_idx   <= div_r[IW-1:0];
                        r_n     <= '0;
                        r_state <= S_PRB_RD;
                    end
                end
                S_PRB_RD: begin
                    r_state <= S_PRB_CHK;
                end
                S_PRB_CHK: begin
                    if (r_slot_q == 16'd0) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_off   <= r_slot_q;
                        r_k     <= '0;
                        r_addr  <= {1'b0, r_slot_q};
                        r_state <= S_CMP_RD;
                    end
                end
                S_CMP_RD: begin
                    r_state <= S_CMP_CHK;
                end
                S_CMP_CHK: begin
                    if (rd_byte != exp_byte) begin
                        // mismatch: step to the next slot or give up
                        if (r_n + SW'(1) == slots) begin
                            r_res_st  <= sit_pkg::ST_FULL;
                            r_res_sym <= '0;
                            r_state   <= S_RES;
                        end else begin
                            r_n     <= r_n + SW'(1);
                            r_idx   <= idx_nx;
                            r_state <= S_PRB_RD;
                        end
                    end else if (last_k) begin
                        r_res_st  <= sit_pkg::ST_OK;
                        r_res_sym <= r_off;
                        r_state   <= S_RES;
                    end else begin
                        r_k     <= r_k + LW'(1);
                        r_addr  <= r_addr + FW'(1);
                        r_state <= S_CMP_RD;
                    end
                end
                S_CHECK: begin
                    if (full) begin
                        r_res_st  <= sit_pkg::ST_FULL;
                        r_res_sym <= '0;
                        r_state   <= S_RES;
                    end else begin
                        r_k     <= '0;
                        r_addr  <= r_fill;
                        r_state <= S_APP;
                    end
                end
                S_APP: begin
                    if (last_k) begin
                        r_count   <= r_count + SW'(1);
                        r_fill    <= r_fill + FW'(r_cmd.len) + FW'(1);
                        r_res_st  <= sit_pkg::ST_OK;
                        r_res_sym <= r_fill[15:0];
                        r_state   <= S_RES;
                    end else begin
                        r_k    <= r_k + LW'(1);
                        r_addr <= r_addr + FW'(1);
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        o_status <= r_res_st;
                        o_symbol <= r_res_sym;
                        o_char   <= 8'd0;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_FET_RD: begin
                    r_state <= S_FET_OUT;
                end
                S_FET_OUT: begin
                    if (out_free) begin
                        o_status <= sit_pkg::ST_OK;
                        o_symbol <= r_cmd.symbol;
                        o_char   <= fet_byte;
                        o_last   <= (fet_byte == 8'd0);
                        if (fet_byte == 8'd0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + LW'(1);
                            r_addr  <= r_addr + FW'(1);
                            r_state <= S_FET_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !m_axis_tvalid)
        else $error("result during clearing pass");

    a_done_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_RES && m_axis_tvalid && o_last))
        else $error("intern done without a result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP && last_k) |=> (r_count == $past(r_count) + SW'(1)))
        else $error("string count did not advance on append");

    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB_CHK) |-> (SW'(r_idx) < slots && r_n < slots))
        else $error("probe index out of range");
`endif

endmodule
